### hdl/fcu_pkg.sv
// ----------------------------------------------------------------------------
// Fly camera package
// Shared types, constants and the sine table for the fly camera update block.
// ----------------------------------------------------------------------------
`default_nettype none
package fcu_pkg;

  localparam int AngleBits = 16;
  localparam int TableDepth = 1024;
  localparam int TableBits = $clog2(TableDepth);
  localparam int QuarterLen = TableDepth / 4;
  localparam logic [AngleBits-1:0] YawReset = AngleBits'(3) << (AngleBits - 2);
  localparam logic signed [AngleBits-1:0] PitchLimit =
    AngleBits'((89 * (2 ** AngleBits) + 180) / 360);

  typedef enum logic [2:0] {
    CMD_FORWARD = 3'd0,
    CMD_BACK    = 3'd1,
    CMD_RIGHT   = 3'd2,
    CMD_LEFT    = 3'd3,
    CMD_UP      = 3'd4,
    CMD_DOWN    = 3'd5,
    CMD_LOOK    = 3'd6,
    CMD_TOGGLE  = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    REG_LOOK_GAIN  = 3'd0,
    REG_MOVE_SPEED = 3'd1,
    REG_START_X    = 3'd2,
    REG_START_Y    = 3'd3,
    REG_START_Z    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
    logic [15:0]        frame_time;
    logic               cursor_changed;
  } item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic               mouse_look_on;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TRIG0, ST_MOVE, ST_ANGLE, ST_TRIG1, ST_OUT
  } state_t;

  typedef logic [QuarterLen-1:0][14:0] sine_tab_t;

  // Quarter-wave sine, Q2.14, computed at elaboration from the series
  // used for the camera; index i is phase i/TableDepth turn in quadrant one.
  function automatic logic [14:0] quarter_sine(input int unsigned i);
    longint unsigned r, x, x2, term, s;
    r = (longint'(i) << 32) / TableDepth;
    r = r & ((64'd1 << 30) - 1);
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    term = (64'd1 << 30) - x2 / 110;
    term = (64'd1 << 30) - ((x2 * term) >> 30) / 72;
    term = (64'd1 << 30) - ((x2 * term) >> 30) / 42;
    term = (64'd1 << 30) - ((x2 * term) >> 30) / 20;
    term = (64'd1 << 30) - ((x2 * term) >> 30) / 6;
    s = (x * term) >> 30;
    s = (s + (64'd1 << 15)) >> 16;
    if (s > 64'd16384) s = 64'd16384;
    return s[14:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int i = 0; i < QuarterLen; i++) tab[i] = quarter_sine($unsigned(i));
    return tab;
  endfunction

  localparam sine_tab_t SineTab = build_sine_tab();

  // Sine of a table index over the full turn.
  function automatic logic signed [15:0] sine_idx(input logic [TableBits-1:0] q);
    logic [TableBits-3:0] f, fn;
    logic [14:0] m;
    f = q[TableBits-3:0];
    fn = ~f + (TableBits-2)'(1);
    if (q[TableBits-2] && f != '0) begin
      m = SineTab[fn];
    end else if (q[TableBits-2]) begin
      m = 15'd16384;
    end else begin
      m = SineTab[f];
    end
    return q[TableBits-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

endpackage
`default_nettype wire

### hdl/fcu_if.sv
// ----------------------------------------------------------------------------
// Fly camera channels
// Valid/ready channel interfaces for items, results and configuration.
// ----------------------------------------------------------------------------
`default_nettype none
interface fcu_item_if;
  logic valid;
  logic ready;
  fcu_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fcu_result_if;
  logic valid;
  logic ready;
  fcu_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fcu_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

### hdl/fcu_front.sv
// ----------------------------------------------------------------------------
// Fly camera front end
// Accepts items into a two-entry queue that decouples input from execution.
// ----------------------------------------------------------------------------
`default_nettype none
module fcu_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire fcu_pkg::item_t in_data,
  output logic                q_valid,
  input  wire logic           q_pop,
  output fcu_pkg::item_t      q_data
);
  import fcu_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = cnt_r != 2'd2;
  assign push = in_valid && in_ready;
  assign q_valid = cnt_r != 2'd0;
  assign q_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_data;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

### hdl/fcu_back.sv
// ----------------------------------------------------------------------------
// Fly camera back end
// Executes one command at a time with a shared 33x33 signed multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
module fcu_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  output logic                  q_pop,
  input  wire fcu_pkg::item_t   q_data,
  input  wire logic [15:0]      look_gain,
  input  wire logic [15:0]      move_speed,
  input  wire logic [31:0]      start_x,
  input  wire logic [31:0]      start_y,
  input  wire logic [31:0]      start_z,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output fcu_pkg::result_t      out_data
);
  import fcu_pkg::*;

  state_t state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic [AngleBits-1:0] yaw_r, pitch_r;
  logic signed [31:0] pos_r [3];
  logic look_r;
  item_t item_r;
  logic signed [15:0] sy_r, cy_r, sp_r, cp_r;
  logic signed [15:0] fx_r, fz_r, ux_r;
  logic [31:0] vel_r;
  logic signed [63:0] prod_r;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic signed [15:0] dir;
  logic signed [63:0] dlt;
  logic signed [63:0] dmv;
  logic signed [33:0] psum;
  logic signed [31:0] psat;
  logic [1:0] axis;
  logic [TableBits-1:0] yq, pq;
  logic signed [15:0] prod14;
  logic signed [31:0] np;
  result_t res_r;
  logic ov_r;

  assign yq = yaw_r[AngleBits-1 -: TableBits];
  assign pq = pitch_r[AngleBits-1 -: TableBits];
  assign mp = ma * mb;
  assign prod14 = 16'((prod_r + 64'sd8192) >>> 14);
  assign q_pop = state_r == ST_IDLE && q_valid && !ov_r;
  assign out_valid = ov_r;
  assign out_data = res_r;

  // Operand select for the shared multiplier by step. The trig passes form
  // cy*cp, sy*cp, cy*sp and sy*sp at steps 1 to 4; a move forms the velocity
  // at step 0 and the deltas along axes 0 to 2 at steps 2 to 4.
  always_comb begin
    ma = '0;
    mb = '0;
    axis = 2'(step_r - 4'd2);
    dir = '0;
    case (item_r.command)
      CMD_FORWARD, CMD_BACK: dir = (axis == 2'd0) ? fx_r : (axis == 2'd1) ? sp_r : fz_r;
      CMD_RIGHT, CMD_LEFT: dir = (axis == 2'd0) ? -sy_r : (axis == 2'd1) ? 16'sd0 : cy_r;
      default: dir = (axis == 2'd1) ? 16'sd16384 : 16'sd0;
    endcase
    case (state_r)
      ST_TRIG0, ST_TRIG1: begin
        ma = (step_r == 4'd1 || step_r == 4'd3) ? 33'(cy_r) : 33'(sy_r);
        mb = (step_r < 4'd3) ? 33'(cp_r) : 33'(sp_r);
      end
      ST_MOVE: begin
        if (step_r == 4'd0) begin
          ma = 33'(move_speed);
          mb = 33'(item_r.frame_time);
        end else begin
          ma = $signed({1'b0, vel_r});
          mb = 33'(dir);
        end
      end
      ST_ANGLE: begin
        ma = 33'(look_gain);
        mb = (step_r == 4'd0) ? 33'(item_r.mouse_dx) : 33'(item_r.mouse_dy);
      end
      default: ;
    endcase
  end

  // The delta for axis k is in prod_r at step k+3 of a move.
  assign dlt = (prod_r + 64'sd2097152) >>> 22;
  always_comb begin
    dmv = item_r.command[0] ? -dlt : dlt;
    psum = 34'(pos_r[2'(step_r - 4'd3)]) + 34'(dmv);
    if (psum > 34'sd2147483647) psat = 32'h7FFF_FFFF;
    else if (psum < -34'sd2147483648) psat = 32'h8000_0000;
    else psat = psum[31:0];
  end

  assign np = 32'($signed(pitch_r)) + 32'(prod_r >>> 8);

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r + 4'd1;
    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (q_pop) state_nxt = ST_TRIG0;
      end
      ST_TRIG0: if (step_r == 4'd4) begin
        step_nxt = '0;
        case (item_r.command)
          CMD_LOOK: state_nxt = (look_r && !item_r.cursor_changed) ? ST_ANGLE : ST_TRIG1;
          CMD_TOGGLE: state_nxt = ST_TRIG1;
          default: state_nxt = ST_MOVE;
        endcase
      end
      ST_MOVE: if (step_r == 4'd5) begin
        step_nxt = '0;
        state_nxt = ST_TRIG1;
      end
      ST_ANGLE: if (step_r == 4'd2) begin
        step_nxt = '0;
        state_nxt = ST_TRIG1;
      end
      ST_TRIG1: if (step_r == 4'd4) begin
        step_nxt = '0;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        step_nxt = '0;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mp);
    if (q_pop) item_r <= q_data;
    if (state_r == ST_TRIG0 || state_r == ST_TRIG1) begin
      if (step_r == 4'd0) begin
        sy_r <= sine_idx(yq);
        cy_r <= sine_idx(yq + TableBits'(TableDepth / 4));
        sp_r <= sine_idx(pq);
        cp_r <= sine_idx(pq + TableBits'(TableDepth / 4));
      end
      if (step_r == 4'd2) fx_r <= prod14;
      if (step_r == 4'd3) fz_r <= prod14;
      if (step_r == 4'd4) ux_r <= -prod14;
    end
    if (state_r == ST_MOVE && step_r == 4'd1) vel_r <= prod_r[31:0];
    if (state_r == ST_OUT) begin
      res_r.pos_x <= pos_r[0];
      res_r.pos_y <= pos_r[1];
      res_r.pos_z <= pos_r[2];
      res_r.front_x <= fx_r;
      res_r.front_y <= sp_r;
      res_r.front_z <= fz_r;
      res_r.up_x <= ux_r;
      res_r.up_y <= cp_r;
      res_r.up_z <= -prod14;
      res_r.mouse_look_on <= look_r;
    end
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r <= '0;
      yaw_r <= YawReset;
      pitch_r <= '0;
      look_r <= 1'b0;
      ov_r <= 1'b0;
      pos_r[0] <= start_x;
      pos_r[1] <= start_y;
      pos_r[2] <= start_z;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      if (state_r == ST_OUT) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (state_r == ST_TRIG0 && step_r == 4'd4 && item_r.command == CMD_TOGGLE)
        look_r <= ~look_r;
      if (state_r == ST_MOVE && step_r >= 4'd3) pos_r[2'(step_r - 4'd3)] <= psat;
      if (state_r == ST_ANGLE && step_r == 4'd1)
        yaw_r <= yaw_r + AngleBits'(prod_r >>> 8);
      if (state_r == ST_ANGLE && step_r == 4'd2) begin
        if (np > 32'(PitchLimit)) pitch_r <= PitchLimit;
        else if (np < -32'(PitchLimit)) pitch_r <= -PitchLimit;
        else pitch_r <= np[AngleBits-1:0];
      end
    end
  end
endmodule
`default_nettype wire

### hdl/fly_camera_update.sv
// ----------------------------------------------------------------------------
// Fly camera update
// Free-look camera: yaw/pitch binary angles and a saturating Q16.16 position.
// ----------------------------------------------------------------------------
// Usage: each transfer on the in_ channel carries one command; every command
// yields exactly one transfer on the out_ channel with the new position, the
// front and up vectors in Q2.14 and the mouse look flag.
// Configuration transfers on the cfg_ channel write look_gain, move_speed and
// the start position; they are always accepted. Write them only while idle.
// Reset also clears the start registers, so the position always starts at
// the origin.
// The back end sequencer runs a trig pass before and after each command,
// which feeds four products through the shared multiplier one per cycle;
// a move adds the velocity and three position deltas, and a look that
// turns the view adds the yaw and pitch updates. One item runs at a time,
// so the back end takes no new item until it is through with the last; a
// two-entry queue in front lets the source deliver items while it works.
// The result sits in an output register; if the receiver stalls, the back end
// holds it and takes no new item until it has been transferred.
// Reset (synchronous, rst_n low) restores the registers to their defaults,
// sets yaw to minus 90 degrees, pitch to zero, look off and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module fly_camera_update (
  input  wire logic clk,
  input  wire logic rst_n,
  fcu_item_if.sink     in_ch,
  fcu_result_if.source out_ch,
  fcu_cfg_if.sink      cfg_ch
);
  import fcu_pkg::*;

  logic [15:0] look_gain_r, move_speed_r;
  logic [31:0] start_r [3];
  logic q_valid, q_pop;
  item_t q_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      look_gain_r <= 16'd4660;
      move_speed_r <= 16'd2048;
      start_r[0] <= '0;
      start_r[1] <= '0;
      start_r[2] <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_LOOK_GAIN: look_gain_r <= cfg_ch.wdata[15:0];
        REG_MOVE_SPEED: move_speed_r <= cfg_ch.wdata[15:0];
        REG_START_X: start_r[0] <= cfg_ch.wdata;
        REG_START_Y: start_r[1] <= cfg_ch.wdata;
        REG_START_Z: start_r[2] <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  fcu_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  // Position resets to zero: reset also clears the start registers.
  fcu_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .look_gain(look_gain_r), .move_speed(move_speed_r),
    .start_x(32'd0 | (start_r[0] & {32{rst_n}})),
    .start_y(32'd0 | (start_r[1] & {32{rst_n}})),
    .start_z(32'd0 | (start_r[2] & {32{rst_n}})),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule
`default_nettype wire
